// ----- rtl/fdsa_pkg.sv -----
package fdsa_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  typedef enum logic [4:0] {
    ActPush = 5'd0,  ActAdd  = 5'd1,  ActSub  = 5'd2,  ActMul  = 5'd3,
    ActDiv  = 5'd4,  ActMod  = 5'd5,  ActDup  = 5'd6,  ActDrop = 5'd7,
    ActSwap = 5'd8,  ActOver = 5'd9,  ActRot  = 5'd10, ActEmit = 5'd11,
    ActCr   = 5'd12, ActDot  = 5'd13, ActEq   = 5'd14, ActLt   = 5'd15,
    ActGt   = 5'd16, ActAnd  = 5'd17, ActOr   = 5'd18, ActNot  = 5'd19
  } action_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StOver = 2'd1, StUnder = 2'd2, StDiv0 = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KNone = 2'd0, KChar = 2'd1, KNum = 2'd2, KNl = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    SIdle, SRd1, SRd2, SRd3, SExec, SDiv, SWr1, SWr2, SWr3, SOut
  } state_e;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [31:0] literal;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         out_kind;
    logic signed [31:0] out_value;
    logic [8:0]         stack_depth;
  } out_t;

  // controller -> datapath
  typedef enum logic [1:0] { RdTop, RdSec, RdThird } rdsel_e;
  typedef enum logic [1:0] { WrSec, WrTop, WrThird, WrNew } wrsel_e;

  typedef struct packed {
    logic   load;
    logic   rd_en;
    rdsel_e rd_sel;
    logic   cap_b;
    logic   cap_a;
    logic   cap_c;
    logic   exec;
    logic   div_start;
    logic   wr_en;
    wrsel_e wr_sel;
    logic   fin;
  } cmd_t;

  typedef struct packed {
    logic fault;
    logic div_busy;
    logic div0;
  } sts_t;

endpackage

// ----- rtl/forth_data_stack_alu_top.sv -----
// Forth data stack ALU.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one request: an
// action code and a literal. Output channel (out_valid_o/out_ready_i/
// out_data_o) returns exactly one response per request: status, printed
// kind and value, and the stack depth afterwards.
// One request is processed at a time. From accept to response valid the
// controller does three stack reads through the single RAM read port,
// then execute, then the write; swap takes a second write and rot a third,
// div and mod run the 32-step radix-2 divider, and a failed request or a
// zero divisor skips the writes. With the receiver ready, the block goes
// idle once the response is taken and only then takes the next request.
// The data stack sits in a 256 x 32 RAM with one read and one write port;
// entries above the depth are never read, so no clearing is needed.
// Reset sets the depth to zero and the controller idle, ready at once.
// If the receiver stalls, the response holds and no request is taken.
module forth_data_stack_alu_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fdsa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fdsa_pkg::out_t out_data_o
);
  import fdsa_pkg::*;

  fdsa_core u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_data_o.stack_depth <= 9'(StackDepth)) else $error("depth beyond stack");
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.out_kind == KNone && out_data_o.out_value == 32'd0)
    else $error("output on error");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");
endmodule

// ----- rtl/fdsa_ram.sv -----
module fdsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/fdsa_div.sv -----
module fdsa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        busy_o,
  output logic [31:0] q_o,
  output logic [31:0] r_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        nq_q, nq_d, nr_q, nr_d;
  logic [32:0] trial;

  assign busy_o = (cnt_q != 6'd0);
  assign trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
  assign q_o = nq_q ? 32'd0 - quo_q : quo_q;
  assign r_o = nr_q ? 32'd0 - rem_q : rem_q;

  always_comb begin
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    nq_d = nq_q; nr_d = nr_q;
    if (start_i) begin
      cnt_d = 6'd32;
      rem_d = '0;
      quo_d = a_i[31] ? 32'd0 - a_i : a_i;
      den_d = b_i[31] ? 32'd0 - b_i : b_i;
      nq_d  = a_i[31] ^ b_i[31];
      nr_d  = a_i[31];
    end else if (busy_o) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; nq_q <= nq_d; nr_q <= nr_d;
  end
endmodule

// ----- rtl/fdsa_datapath.sv -----
module fdsa_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdsa_pkg::in_t   req_i,
  input  fdsa_pkg::cmd_t  cmd_i,
  output fdsa_pkg::sts_t  sts_o,
  output fdsa_pkg::out_t  rsp_o
);
  import fdsa_pkg::*;

  logic [4:0]      act_q;
  logic [31:0]     lit_q, a_q, b_q, c_q, res_q, res_d, prod;
  logic [CntW-1:0] dep_q, dep_d;
  logic [1:0]      st_q, st_d, kind_q, kind_d, need;
  logic            grow;
  logic [31:0]     val_q, val_d;
  logic [PtrW-1:0] raddr, waddr;
  logic [31:0]     rdata, wdata, q, r, div_res;
  logic            div_busy;

  fdsa_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(cmd_i.wr_en), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.rd_en), .raddr_i(raddr), .rdata_o(rdata)
  );

  fdsa_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .a_i(a_q), .b_i(b_q),
    .busy_o(div_busy), .q_o(q), .r_o(r)
  );

  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    case (req_i.action)
      ActPush: grow = 1'b1;
      ActAdd, ActSub, ActMul, ActDiv, ActMod, ActEq, ActLt, ActGt, ActAnd, ActOr,
      ActSwap: need = 2'd2;
      ActDup: begin need = 2'd1; grow = 1'b1; end
      ActDrop, ActEmit, ActDot, ActNot: need = 2'd1;
      ActOver: begin need = 2'd2; grow = 1'b1; end
      ActRot: need = 2'd3;
      default: ;
    endcase
  end
  assign sts_o.fault    = (st_q != StOk);
  assign sts_o.div_busy = div_busy;
  assign sts_o.div0     = (b_q == 32'd0);

  always_comb begin
    case (cmd_i.rd_sel)
      RdTop:   raddr = PtrW'(dep_q - CntW'(1));
      RdSec:   raddr = PtrW'(dep_q - CntW'(2));
      default: raddr = PtrW'(dep_q - CntW'(3));
    endcase
    case (cmd_i.wr_sel)
      WrSec:   begin waddr = PtrW'(dep_q - CntW'(2)); wdata = res_q; end
      WrTop: begin
        waddr = PtrW'(dep_q - CntW'(1));
        case (act_q)
          ActSwap: wdata = a_q;
          ActRot:  wdata = c_q;
          default: wdata = res_q;
        endcase
      end
      WrThird: begin waddr = PtrW'(dep_q - CntW'(3)); wdata = a_q; end
      default: begin waddr = PtrW'(dep_q);             wdata = res_q; end
    endcase
  end

  assign prod = a_q * b_q;

  always_comb begin
    case (act_q)
      ActPush, ActDup, ActOver: dep_d = dep_q + CntW'(1);
      ActAdd, ActSub, ActMul, ActDiv, ActMod, ActEq, ActLt, ActGt,
      ActAnd, ActOr, ActDrop, ActEmit, ActDot: dep_d = dep_q - CntW'(1);
      default: dep_d = dep_q;
    endcase
  end

  always_comb begin
    res_d = res_q; st_d = st_q; kind_d = kind_q; val_d = val_q;
    if (cmd_i.load) begin
      st_d = StOk; kind_d = KNone; val_d = '0;
      if (CntW'(need) > dep_q) st_d = StUnder;
      else if (grow && dep_q == CntW'(StackDepth)) st_d = StOver;
    end
    if (cmd_i.exec) begin
      case (act_q)
        ActPush: res_d = lit_q;
        ActAdd:  res_d = a_q + b_q;
        ActSub:  res_d = a_q - b_q;
        ActMul:  res_d = prod;
        ActDiv, ActMod: begin
          if (b_q == 32'd0) st_d = StDiv0;
        end
        ActDup:  res_d = b_q;
        ActSwap: res_d = b_q;
        ActOver: res_d = a_q;
        ActRot:  res_d = b_q;
        ActEmit: begin val_d = b_q; kind_d = KChar; end
        ActCr:   kind_d = KNl;
        ActDot:  begin val_d = b_q; kind_d = KNum; end
        ActEq:   res_d = {32{a_q == b_q}};
        ActLt:   res_d = {32{$signed(a_q) < $signed(b_q)}};
        ActGt:   res_d = {32{$signed(b_q) < $signed(a_q)}};
        ActAnd:  res_d = a_q & b_q;
        ActOr:   res_d = a_q | b_q;
        ActNot:  res_d = ~b_q;
        default: ;
      endcase
    end
  end

  assign div_res = (act_q == ActDiv) ? q : r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dep_q <= '0;
    end else if (cmd_i.fin) begin
      dep_q <= dep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= req_i.action;
      lit_q <= req_i.literal;
    end
    if (cmd_i.cap_b) b_q <= rdata;
    if (cmd_i.cap_a) a_q <= rdata;
    if (cmd_i.cap_c) c_q <= rdata;
    if (cmd_i.div_start) res_q <= res_q;
    else if (cmd_i.exec) res_q <= res_d;
    else if (!div_busy && (act_q == ActDiv || act_q == ActMod)) res_q <= div_res;
    st_q <= st_d; kind_q <= kind_d; val_q <= val_d;
  end

  assign rsp_o.status      = st_q;
  assign rsp_o.out_kind    = kind_q;
  assign rsp_o.out_value   = val_q;
  assign rsp_o.stack_depth = 9'(dep_q);
endmodule

// ----- rtl/fdsa_ctrl.sv -----
module fdsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic [4:0]     action_i,
  input  fdsa_pkg::sts_t sts_i,
  output fdsa_pkg::cmd_t cmd_o
);
  import fdsa_pkg::*;

  state_e state_q, state_d;
  logic [4:0] act_q;
  logic       dnow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) act_q <= action_i;
  end

  assign dnow = (act_q == ActDiv) || (act_q == ActMod);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SRd1;
        end
      end
      SRd1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RdTop;
        state_d = SRd2;
      end
      SRd2: begin
        cmd_o.cap_b = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RdSec;
        state_d = SRd3;
      end
      SRd3: begin
        cmd_o.cap_a = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RdThird;
        state_d = SExec;
      end
      SExec: begin
        cmd_o.cap_c = 1'b1;
        state_d = SOut;
        if (!sts_i.fault) begin
          if (dnow && !sts_i.div0) begin
            cmd_o.div_start = 1'b1;
            state_d = SDiv;
          end else begin
            cmd_o.exec = 1'b1;
            if (!dnow) state_d = SWr1;
          end
        end
      end
      SDiv: begin
        if (!sts_i.div_busy) state_d = SWr1;
      end
      SWr1: begin
        state_d = SOut;
        cmd_o.fin = 1'b1;
        case (act_q)
          ActPush, ActDup, ActOver: begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_sel = WrNew;
          end
          ActAdd, ActSub, ActMul, ActDiv, ActMod, ActEq, ActLt, ActGt,
          ActAnd, ActOr: begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_sel = WrSec;
          end
          ActSwap, ActRot: begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_sel = WrSec; state_d = SWr2;
            cmd_o.fin = 1'b0;
          end
          ActNot: begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_sel = WrTop;
          end
          default: ;
        endcase
      end
      SWr2: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_sel = WrTop;
        state_d = SOut;
        cmd_o.fin = 1'b1;
        if (act_q == ActRot) begin
          cmd_o.fin = 1'b0;
          state_d = SWr3;
        end
      end
      SWr3: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_sel = WrThird;
        cmd_o.fin = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

// ----- rtl/fdsa_core.sv -----
module fdsa_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fdsa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fdsa_pkg::out_t out_data_o
);
  import fdsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fdsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .action_i(in_data_i.action), .sts_i(sts), .cmd_o(cmd)
  );

  fdsa_datapath u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .rsp_o(out_data_o)
  );
endmodule

// ----- sim/forth_data_stack_alu_checker.sv -----
module forth_data_stack_alu_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  fdsa_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  fdsa_pkg::out_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o,
  output int unsigned    seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fdsa_pkg::*;

  logic [31:0] shadow_stack [StackDepth];
  int unsigned shadow_depth;
  out_t        expected_q [$];

  function automatic logic [31:0] signed_lt(logic [31:0] a, logic [31:0] b);
    return ($signed(a) < $signed(b)) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  function automatic out_t forth_exec(in_t req);
    out_t        rsp;
    int unsigned d;
    int unsigned need;
    int unsigned grow;
    logic [31:0] a, b, t, ma, mb, qq, rr;
    d = shadow_depth;
    need = 0;
    grow = 0;
    a = '0;
    b = '0;
    rsp = '0;
    rsp.status = StOk;
    rsp.out_kind = KNone;
    case (req.action)
      ActPush: grow = 1;
      ActAdd, ActSub, ActMul, ActDiv, ActMod, ActEq, ActLt, ActGt, ActAnd, ActOr,
      ActSwap: need = 2;
      ActDup: begin
        need = 1;
        grow = 1;
      end
      ActDrop, ActEmit, ActDot, ActNot: need = 1;
      ActOver: begin
        need = 2;
        grow = 1;
      end
      ActRot: need = 3;
      default: ;
    endcase
    if (d < need) begin
      rsp.status = StUnder;
    end else if (d + grow > StackDepth) begin
      rsp.status = StOver;
    end else begin
      if (need >= 1) b = shadow_stack[d-1];
      if (need >= 2) a = shadow_stack[d-2];
      case (req.action)
        ActPush: begin
          shadow_stack[d] = req.literal;
          d++;
        end
        ActAdd: begin shadow_stack[d-2] = a + b; d--; end
        ActSub: begin shadow_stack[d-2] = a - b; d--; end
        ActMul: begin shadow_stack[d-2] = a * b; d--; end
        ActDiv, ActMod: begin
          if (b == 0) begin
            rsp.status = StDiv0;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            qq = ma / mb;
            rr = ma % mb;
            if (a[31] != b[31]) qq = -qq;
            if (a[31]) rr = -rr;
            shadow_stack[d-2] = (req.action == ActDiv) ? qq : rr;
            d--;
          end
        end
        ActDup: begin shadow_stack[d] = b; d++; end
        ActDrop: d--;
        ActSwap: begin shadow_stack[d-2] = b; shadow_stack[d-1] = a; end
        ActOver: begin shadow_stack[d] = a; d++; end
        ActRot: begin
          t = shadow_stack[d-3];
          shadow_stack[d-3] = a;
          shadow_stack[d-2] = b;
          shadow_stack[d-1] = t;
        end
        ActEmit: begin rsp.out_value = b; rsp.out_kind = KChar; d--; end
        ActCr: rsp.out_kind = KNl;
        ActDot: begin rsp.out_value = b; rsp.out_kind = KNum; d--; end
        ActEq: begin shadow_stack[d-2] = (a == b) ? '1 : '0; d--; end
        ActLt: begin shadow_stack[d-2] = signed_lt(a, b); d--; end
        ActGt: begin shadow_stack[d-2] = signed_lt(b, a); d--; end
        ActAnd: begin shadow_stack[d-2] = a & b; d--; end
        ActOr: begin shadow_stack[d-2] = a | b; d--; end
        ActNot: shadow_stack[d-1] = ~b;
        default: ;
      endcase
    end
    shadow_depth = d;
    rsp.stack_depth = d[8:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t        want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      shadow_depth = 0;
      expected_q.delete();
      fail_count_o <= 0;
      seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(forth_exec(in_data_i));
      if (out_valid_i && out_ready_i) begin
        seen_o <= seen_o + 1;
        if (expected_q.size() == 0) begin
          $error("response with no request outstanding");
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_data_i.status);
            errs++;
          end
          if (out_data_i.out_kind !== want.out_kind) begin
            $error("out_kind exp %0d got %0d", want.out_kind, out_data_i.out_kind);
            errs++;
          end
          if (out_data_i.out_value !== want.out_value) begin
            $error("out_value exp %0d got %0d", want.out_value, out_data_i.out_value);
            errs++;
          end
          if (out_data_i.stack_depth !== want.stack_depth) begin
            $error("stack_depth exp %0d got %0d", want.stack_depth,
                   out_data_i.stack_depth);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= expected_q.size();
    end
  end
endmodule

// ----- sim/tb_forth_data_stack_alu_top.sv -----
module tb_forth_data_stack_alu_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdsa_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  int unsigned fail_count, pending, seen;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned model_depth = 0;
  logic        stall_rx = 1'b0;
  logic [8:0]  last_depth = '0;

  always #2 clk_i = ~clk_i;

  forth_data_stack_alu_top u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  forth_data_stack_alu_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  function automatic int unsigned short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(0, 9);
      5: return -$urandom_range(1, 9);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [4:0] act, input logic [31:0] lit);
    int unsigned gap;
    gap = short_or_long_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data <= '{action: act, literal: lit};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  // rough depth tracking only to steer the random mix
  function automatic void track_depth(logic [4:0] act);
    case (act)
      ActPush, ActDup, ActOver:
        if (model_depth < StackDepth) model_depth++;
      ActAdd, ActSub, ActMul, ActDiv, ActMod, ActDrop, ActEmit, ActDot,
      ActEq, ActLt, ActGt, ActAnd, ActOr:
        if (model_depth > 0) model_depth--;
      default: ;
    endcase
  endfunction

  task automatic send_tracked(input logic [4:0] act, input logic [31:0] lit);
    send_request(act, lit);
    track_depth(act);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (out_valid && out_ready) last_depth <= out_data.stack_depth;
  end

  always @(posedge clk_i) begin
    if (stall_rx || $urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && $urandom_range(0, 49) == 0)
      stall_rx <= ~stall_rx & ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [4:0]  act;
    int unsigned r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // underflow on empty stack, including dup; then unknown codes, INT_MIN / -1 and zero divisor
    send_tracked(ActDup, 0);
    send_tracked(ActDrop, 0);
    send_tracked(ActAdd, 0);
    send_tracked(ActRot, 0);
    send_tracked(ActCr, 0);
    send_tracked(5'd20, 0);
    send_tracked(5'd31, 32'hFFFF_FFFF);
    send_tracked(ActPush, 32'h8000_0000);
    send_tracked(ActPush, 32'hFFFF_FFFF);
    send_tracked(ActDiv, 0);
    send_tracked(ActPush, 32'h8000_0000);
    send_tracked(ActPush, 32'hFFFF_FFFF);
    send_tracked(ActMod, 0);
    send_tracked(ActPush, 0);
    send_tracked(ActDiv, 0);
    send_tracked(ActMod, 0);
    send_tracked(ActPush, 32'h7FFF_FFFF);
    send_tracked(ActOver, 0);
    send_tracked(ActRot, 0);
    send_tracked(ActSwap, 0);
    send_tracked(ActLt, 0);
    send_tracked(ActNot, 0);
    send_tracked(ActEmit, 0);
    send_tracked(ActDot, 0);

    // sender holds off until everything has drained
    wait_drained();
    model_depth = {23'd0, last_depth};

    // fill to the top, then hit overflow
    while (model_depth < StackDepth) send_tracked(ActPush, $urandom);
    send_tracked(ActPush, 32'h1234_5678);
    send_tracked(ActDup, 0);
    send_tracked(ActOver, 0);
    send_tracked(ActSwap, 0);
    while (model_depth > 0) send_tracked(ActDot, 0);

    for (int i = 0; i < 800; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) act = 5'($urandom_range(20, 31));
      else if (model_depth < 3 || r < 25) act = ActPush;
      else if (model_depth > 200 && r < 70) act = ActDot;
      else act = 5'($urandom_range(1, 19));
      send_tracked(act, pick_value());
    end
    while (model_depth > 0) send_tracked(ActDrop, 0);

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Ran %0d requests (%0d responses): all primitives, under/overflow,",
             sent, seen);
    $display("zero divisor and INT_MIN / -1, with random stalls on both channels.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
